>>> src/json_string_unescaper_assert.svh
`ifndef JSON_STRING_UNESCAPER_ASSERT_SVH
`define JSON_STRING_UNESCAPER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define JSU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("jsu assertion failed");

// Next-cycle implication, checked outside reset.
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("jsu assertion failed");

`endif

>>> src/jsu_pkg.sv
package jsu_pkg;

	typedef enum logic [2:0] {
		KIND_DATA   = 3'd0,
		KIND_QUOTE  = 3'd1,
		KIND_NUL    = 3'd2,
		KIND_FULL   = 3'd3,
		KIND_NOOPEN = 3'd4
	} kind_t;

	localparam int unsigned MAX_RESULTS = 4;

	localparam logic [9:0] MAX_LEN_RESET = 10'd63;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;

	localparam logic [15:0] CP_LIMIT_1 = 16'h0080;
	localparam logic [15:0] CP_LIMIT_2 = 16'h0800;
	localparam logic [7:0]  LEAD_2     = 8'hC0;
	localparam logic [7:0]  LEAD_3     = 8'hE0;
	localparam logic [7:0]  CONT_MARK  = 8'h80;
	localparam logic [7:0]  CONT_MASK  = 8'h3F;

	// Hex digit value; anything that is not a hex digit counts as zero.
	function automatic logic [3:0] nibble_of(input logic [7:0] b);
		logic [7:0] v;
		v = 8'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			v = b - 8'h30;
		end else if (b >= 8'h61 && b <= 8'h66) begin
			v = b - 8'h57;
		end else if (b >= 8'h41 && b <= 8'h46) begin
			v = b - 8'h37;
		end
		return v[3:0];
	endfunction

endpackage

>>> src/json_string_unescaper.sv
// JSON string unescaper.
// Input channel (in_valid/in_ready/in_byte) takes the raw text of a quoted
// JSON string one byte per transfer. Output channel (out_valid/out_ready)
// delivers result items: a decoded byte (kind data) or an end marker
// (closed by quote, ended by NUL, length full, no opening quote). The last
// flag marks the final result caused by one input byte; consumed is low only
// on a length-full end, whose byte is dropped.
// Configuration: cfg_valid/cfg_ready/max_len writes the length limit; the
// port is always ready and the limit resets to 63.
// Timing: a byte is decoded in the cycle it is accepted and its results sit
// in the output group register in the next cycle. Plain text, one result or
// none per byte, streams at one byte per cycle while out_ready is high. A
// \uXXXX escape expands to up to three UTF-8 bytes plus a possible end
// marker; the group register drains one result per cycle while out_ready is
// high, and in_ready stays low until the final result of the group transfers.
// Reset clears the mode to idle (waiting for the opening quote), empties the
// output group and restores max_len. When the receiver stalls, the current
// result holds steady and in_ready drops until the group drains.
`include "json_string_unescaper_assert.svh"

module json_string_unescaper
	import jsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [9:0] max_len,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [2:0] kind,
	output logic       last,
	output logic       consumed
);

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_BODY,
		MODE_ESC,
		MODE_HEX
	} mode_t;

	// Decoder state.
	mode_t       mode_q;
	logic [1:0]  hex_cnt_q;
	logic [15:0] cp_q;
	logic [9:0]  out_cnt_q;
	logic [9:0]  max_len_q;

	// Output group register: up to four results of one input byte.
	logic [7:0]  byte_s1 [MAX_RESULTS];
	kind_t       kind_s1 [MAX_RESULTS];
	logic        cons_s1 [MAX_RESULTS];
	logic [2:0]  cnt_s1;
	logic [1:0]  head_q;

	// Next-group and next-state values.
	logic [7:0]  byte_c [MAX_RESULTS];
	kind_t       kind_c [MAX_RESULTS];
	logic        cons_c [MAX_RESULTS];
	logic [2:0]  cnt_c;
	mode_t       mode_c;
	logic [1:0]  hex_cnt_c;
	logic [15:0] cp_c;
	logic [9:0]  out_cnt_c;

	// UTF-8 encoder of the code point to emit.
	logic [15:0] cp_shift;
	logic [15:0] cp_src;
	logic [7:0]  enc_c [3];
	logic [1:0]  enc_len;
	logic [10:0] room_sum;
	logic        enc_room;
	logic        one_room;

	logic in_fire;
	logic out_fire;
	logic head_last;

	assign cfg_ready = 1'b1;

	assign head_last = ({1'b0, head_q} == (cnt_s1 - 3'd1));
	assign out_valid = (cnt_s1 != 3'd0);
	assign in_ready  = !out_valid || (out_ready && head_last);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;

	assign out_byte = byte_s1[head_q];
	assign kind     = kind_s1[head_q];
	assign consumed = cons_s1[head_q];
	assign last     = head_last;

	assign cp_shift = {cp_q[11:0], nibble_of(in_byte)};
	assign cp_src   = (in_byte == CH_NUL) ? cp_q : cp_shift;

	always_comb begin
		if (cp_src < CP_LIMIT_1) begin
			enc_len  = 2'd1;
			enc_c[0] = cp_src[7:0];
			enc_c[1] = 8'd0;
			enc_c[2] = 8'd0;
		end else if (cp_src < CP_LIMIT_2) begin
			enc_len  = 2'd2;
			enc_c[0] = LEAD_2 | {3'd0, cp_src[10:6]};
			enc_c[1] = CONT_MARK | ({2'd0, cp_src[5:0]} & CONT_MASK);
			enc_c[2] = 8'd0;
		end else begin
			enc_len  = 2'd3;
			enc_c[0] = LEAD_3 | {4'd0, cp_src[15:12]};
			enc_c[1] = CONT_MARK | ({2'd0, cp_src[11:6]} & CONT_MASK);
			enc_c[2] = CONT_MARK | ({2'd0, cp_src[5:0]} & CONT_MASK);
		end
	end

	assign room_sum = {1'b0, out_cnt_q} + {9'd0, enc_len};
	assign enc_room = (room_sum <= {1'b0, max_len_q});
	assign one_room = (out_cnt_q < max_len_q);

	always_comb begin
		logic [7:0] esc_byte;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			byte_c[i] = 8'd0;
			kind_c[i] = KIND_DATA;
			cons_c[i] = 1'b1;
		end
		cnt_c     = 3'd0;
		mode_c    = mode_q;
		hex_cnt_c = hex_cnt_q;
		cp_c      = cp_q;
		out_cnt_c = out_cnt_q;
		esc_byte  = in_byte;

		case (in_byte)
			CH_B:    esc_byte = 8'h08;
			CH_F:    esc_byte = 8'h0C;
			CH_N:    esc_byte = 8'h0A;
			CH_R:    esc_byte = 8'h0D;
			CH_T:    esc_byte = 8'h09;
			default: esc_byte = in_byte;
		endcase

		case (mode_q)
			MODE_IDLE: begin
				if (in_byte == CH_QUOTE) begin
					mode_c    = MODE_BODY;
					out_cnt_c = 10'd0;
				end else begin
					kind_c[0] = KIND_NOOPEN;
					cnt_c     = 3'd1;
				end
			end
			MODE_BODY: begin
				if (in_byte == CH_NUL) begin
					kind_c[0] = KIND_NUL;
					cnt_c     = 3'd1;
				end else if (in_byte == CH_QUOTE) begin
					kind_c[0] = KIND_QUOTE;
					cnt_c     = 3'd1;
				end else if (!one_room) begin
					kind_c[0] = KIND_FULL;
					cons_c[0] = 1'b0;
					cnt_c     = 3'd1;
				end else if (in_byte == CH_BSL) begin
					mode_c = MODE_ESC;
				end else begin
					byte_c[0] = in_byte;
					cnt_c     = 3'd1;
					out_cnt_c = out_cnt_q + 10'd1;
				end
			end
			MODE_ESC: begin
				if (in_byte == CH_NUL) begin
					kind_c[0] = KIND_NUL;
					cnt_c     = 3'd1;
				end else if (in_byte == CH_U) begin
					mode_c    = MODE_HEX;
					hex_cnt_c = 2'd0;
					cp_c      = 16'd0;
				end else begin
					mode_c = MODE_BODY;
					if (one_room) begin
						byte_c[0] = esc_byte;
						cnt_c     = 3'd1;
						out_cnt_c = out_cnt_q + 10'd1;
					end
				end
			end
			default: begin
				if (in_byte == CH_NUL || hex_cnt_q == 2'd3) begin
					// Emit the code point, dropped whole when room is short.
					if (enc_room) begin
						for (int i = 0; i < 3; i++) begin
							byte_c[i] = enc_c[i];
						end
						cnt_c     = {1'b0, enc_len};
						out_cnt_c = room_sum[9:0];
					end
					hex_cnt_c = 2'd0;
					cp_c      = 16'd0;
					mode_c    = MODE_BODY;
				end else begin
					cp_c      = cp_shift;
					hex_cnt_c = hex_cnt_q + 2'd1;
				end
				if (in_byte == CH_NUL) begin
					// Append the end marker after the partial code point.
					kind_c[cnt_c[1:0]] = KIND_NUL;
					byte_c[cnt_c[1:0]] = 8'd0;
					cnt_c              = cnt_c + 3'd1;
				end
			end
		endcase

		// Every end returns to idle and clears the string state.
		if (cnt_c != 3'd0 && kind_c[cnt_c[1:0] - 2'd1] != KIND_DATA) begin
			mode_c    = MODE_IDLE;
			hex_cnt_c = 2'd0;
			cp_c      = 16'd0;
			out_cnt_c = 10'd0;
		end
	end

	// Decoder state and limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			hex_cnt_q <= 2'd0;
			cp_q      <= 16'd0;
			out_cnt_q <= 10'd0;
			max_len_q <= MAX_LEN_RESET;
		end else begin
			if (in_fire) begin
				mode_q    <= mode_c;
				hex_cnt_q <= hex_cnt_c;
				cp_q      <= cp_c;
				out_cnt_q <= out_cnt_c;
			end
			if (cfg_valid) begin
				max_len_q <= max_len;
			end
		end
	end

	// Group control: load on an accepted byte, advance one result per transfer,
	// and empty the group once its final result transfers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1 <= 3'd0;
			head_q <= 2'd0;
		end else if (in_fire) begin
			cnt_s1 <= cnt_c;
			head_q <= 2'd0;
		end else if (out_fire) begin
			if (head_last) begin
				cnt_s1 <= 3'd0;
				head_q <= 2'd0;
			end else begin
				head_q <= head_q + 2'd1;
			end
		end
	end

	// Group payload: no reset needed.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int i = 0; i < MAX_RESULTS; i++) begin
				byte_s1[i] <= byte_c[i];
				kind_s1[i] <= kind_c[i];
				cons_s1[i] <= cons_c[i];
			end
		end
	end

	`JSU_ASSERT_NOW(a_end_is_last, clk, arst_n, out_valid && kind != KIND_DATA, last)
	`JSU_ASSERT_NOW(a_end_byte_zero, clk, arst_n, out_valid && kind != KIND_DATA,
		out_byte == 8'd0)
	`JSU_ASSERT_NOW(a_drop_only_full, clk, arst_n, out_valid && !consumed, kind == KIND_FULL)
	`JSU_ASSERT_NEXT(a_group_continues, clk, arst_n, out_fire && !last, out_valid)

endmodule

>>> tb/sv/jsu_checker.sv
`timescale 1ns / 1ps

module jsu_checker
	import jsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [9:0] cfg_max_len,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_byte,
	input  logic [2:0] kind,
	input  logic       last,
	input  logic       consumed,
	output int         fails,
	output int         pending,
	output int         checked
);

	typedef enum logic [1:0] {ST_IDLE, ST_BODY, ST_ESC, ST_HEX} scan_t;

	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		logic       last;
		logic       consumed;
	} decoded_t;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_LA   = 8'h61;
	localparam logic [7:0] CH_LF   = 8'h66;
	localparam logic [7:0] CH_UA   = 8'h41;
	localparam logic [7:0] CH_UF   = 8'h46;

	decoded_t    decoded_q[$];
	scan_t       scan;
	logic [1:0]  digits;
	logic [15:0] cp;
	logic [9:0]  kept;
	logic [9:0]  limit;

	initial begin
		fails = 0;
		checked = 0;
		pending = 0;
	end

	function automatic bit room(input int n);
		return int'(kept) + n <= int'(limit);
	endfunction

	function automatic void keep_byte(input logic [7:0] d);
		kept = kept + 10'd1;
		decoded_q.push_back('{data: d, kind: KIND_DATA, last: 1'b0, consumed: 1'b1});
	endfunction

	function automatic void close_string(input kind_t k, input logic c);
		scan = ST_IDLE;
		digits = 2'd0;
		cp = 16'd0;
		kept = 10'd0;
		decoded_q.push_back('{data: 8'h00, kind: k, last: 1'b0, consumed: c});
	endfunction

	// Whole encodings only: a sequence that does not fit is dropped entirely.
	function automatic void emit_utf8(input logic [15:0] u);
		if (u < CP_LIMIT_1) begin
			if (room(1))
				keep_byte(u[7:0]);
		end else if (u < CP_LIMIT_2) begin
			if (room(2)) begin
				keep_byte(LEAD_2 | {3'b000, u[10:6]});
				keep_byte(CONT_MARK | {2'b00, u[5:0]});
			end
		end else if (room(3)) begin
			keep_byte(LEAD_3 | {4'b0000, u[15:12]});
			keep_byte(CONT_MARK | {2'b00, u[11:6]});
			keep_byte(CONT_MARK | {2'b00, u[5:0]});
		end
	endfunction

	function automatic void decode_byte(input logic [7:0] b);
		int         first;
		logic [3:0] nib;
		logic [7:0] esc;
		first = decoded_q.size();
		case (scan)
			ST_IDLE: begin
				if (b == CH_QUOTE) begin
					scan = ST_BODY;
					kept = 10'd0;
				end else begin
					close_string(KIND_NOOPEN, 1'b1);
				end
			end
			ST_BODY: begin
				if (b == CH_NUL)
					close_string(KIND_NUL, 1'b1);
				else if (b == CH_QUOTE)
					close_string(KIND_QUOTE, 1'b1);
				else if (kept >= limit)
					close_string(KIND_FULL, 1'b0);
				else if (b == CH_BSL)
					scan = ST_ESC;
				else
					keep_byte(b);
			end
			ST_ESC: begin
				if (b == CH_NUL) begin
					close_string(KIND_NUL, 1'b1);
				end else if (b == CH_U) begin
					scan = ST_HEX;
					digits = 2'd0;
					cp = 16'd0;
				end else begin
					case (b)
						CH_B: esc = 8'h08;
						CH_F: esc = 8'h0C;
						CH_N: esc = 8'h0A;
						CH_R: esc = 8'h0D;
						CH_T: esc = 8'h09;
						default: esc = b;
					endcase
					if (room(1))
						keep_byte(esc);
					scan = ST_BODY;
				end
			end
			default: begin
				if (b == CH_NUL) begin
					emit_utf8(cp);
					close_string(KIND_NUL, 1'b1);
				end else begin
					if (b >= CH_ZERO && b <= CH_NINE)
						nib = b[3:0];
					else if ((b >= CH_LA && b <= CH_LF) || (b >= CH_UA && b <= CH_UF))
						nib = b[3:0] + 4'd9;
					else
						nib = 4'd0;
					cp = {cp[11:0], nib};
					if (digits == 2'd3) begin
						emit_utf8(cp);
						digits = 2'd0;
						cp = 16'd0;
						scan = ST_BODY;
					end else begin
						digits = digits + 2'd1;
					end
				end
			end
		endcase
		if (decoded_q.size() > first)
			decoded_q[decoded_q.size() - 1].last = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		decoded_t want;
		if (!arst_n) begin
			decoded_q.delete();
			scan = ST_IDLE;
			digits = 2'd0;
			cp = 16'd0;
			kept = 10'd0;
			limit = MAX_LEN_RESET;
			pending = 0;
		end else begin
			// Compare results first so a stray one cannot match a fresh expectation.
			if (out_valid && out_ready) begin
				if (decoded_q.size() == 0) begin
					$error("unexpected result: out_byte=%02h kind=%0d last=%0b consumed=%0b",
						out_byte, kind, last, consumed);
					fails++;
				end else begin
					want = decoded_q.pop_front();
					checked++;
					if (out_byte !== want.data) begin
						$error("out_byte: expected %02h, got %02h", want.data, out_byte);
						fails++;
					end
					if (kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, kind);
						fails++;
					end
					if (last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, last);
						fails++;
					end
					if (consumed !== want.consumed) begin
						$error("consumed: expected %0b, got %0b", want.consumed, consumed);
						fails++;
					end
				end
			end
			if (in_valid && in_ready)
				decode_byte(in_byte);
			if (cfg_valid && cfg_ready)
				limit = cfg_max_len;
			pending = decoded_q.size();
		end
	end

endmodule

>>> tb/sv/tb_json_string_unescaper.sv
`timescale 1ns / 1ps

module tb_json_string_unescaper
	import jsu_pkg::*;
();

	// Plain characters used to build string text.
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_X     = 8'h78;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [9:0] cfg_max_len;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic [2:0] kind;
	logic       last;
	logic       consumed;

	int fails;
	int pending;
	int checked;
	int sent = 0;
	int settings = 1;
	bit tx_gaps = 1'b0;
	bit rx_gaps = 1'b0;
	int rx_hold = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	json_string_unescaper dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.max_len  (cfg_max_len),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte (out_byte),
		.kind     (kind),
		.last     (last),
		.consumed (consumed)
	);

	jsu_checker scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_max_len(cfg_max_len),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.kind       (kind),
		.last       (last),
		.consumed   (consumed),
		.fails      (fails),
		.pending    (pending),
		.checked    (checked)
	);

	// Result receiver: draw a stall before every result under rx_gaps, or take
	// a long hold when the stimulus asks for one. The hold is counted here, in cycles.
	initial begin : receiver
		int hold;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			hold = rx_gaps ? $urandom_range(17, 0) : 0;
			if (rx_hold > 0) begin
				hold = rx_hold;
				rx_hold = 0;
			end
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			// Raise ready once; a zero stall leaves it high from the last transfer.
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// Offer one raw byte and hold it until the transfer. Valid stays high
	// into the next call, so every other wait must drop it first.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		@(negedge clk);
		gap = tx_gaps ? $urandom_range(17, 0) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		do @(posedge clk); while (!(in_valid && in_ready));
		sent++;
	endtask

	// Drop valid, wait until every predicted result has transferred, then
	// give the pipeline a little slack for bytes with no result.
	task automatic wait_results_done();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	// Write the length limit only while nothing is in flight.
	task automatic write_limit(input logic [9:0] value);
		wait_results_done();
		cfg_valid <= 1'b1;
		cfg_max_len <= value;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// Send a \uXXXX escape; with junk allowed, a digit now and then becomes
	// a byte that is not a hex digit (and so counts as nibble zero).
	task automatic send_code_point(input logic [15:0] u, input bit junk);
		logic [3:0] nib;
		logic [7:0] b;
		send_byte(CH_BSL);
		send_byte(CH_U);
		for (int d = 3; d >= 0; d--) begin
			nib = u[d*4 +: 4];
			if (nib < 4'd10)
				b = CH_ZERO + nib;
			else
				b = ($urandom_range(1, 0) ? CH_LA : CH_UA) - 8'd10 + nib;
			if (junk && $urandom_range(9, 0) == 0)
				b = 8'($urandom_range(255, 8'h67));
			send_byte(b);
		end
	endtask

	// One string: opening quote, a mix of plain bytes and escapes, then a
	// closing quote or NUL. Some strings break off inside an escape.
	task automatic send_string();
		logic [7:0]  b;
		logic [15:0] u;
		logic [7:0]  esc_set [9];
		int          n;
		int          r;
		bit          done;
		esc_set = '{CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_X};
		done = 1'b0;
		n = $urandom_range(10, 0);
		send_byte(CH_QUOTE);
		for (int i = 0; i < n && !done; i++) begin
			r = $urandom_range(99, 0);
			if (r < 45) begin
				b = 8'($urandom_range(255, 1));
				if (b == CH_QUOTE || b == CH_BSL)
					b = b ^ 8'h01;
				send_byte(b);
			end else if (r < 65) begin
				b = esc_set[$urandom_range(8, 0)];
				// Any other escaped byte passes through literally.
				if (b == CH_X) begin
					b = 8'($urandom_range(255, 1));
					if (b == CH_U)
						b = CH_SLASH;
				end
				send_byte(CH_BSL);
				send_byte(b);
			end else if (r < 90) begin
				case ($urandom_range(3, 0))
					0: u = 16'($urandom_range(16'h007F, 16'h0000));
					1: u = 16'($urandom_range(16'h07FF, 16'h0080));
					2: u = 16'($urandom_range(16'hFFFF, 16'h0800));
					default: u = 16'($urandom);
				endcase
				send_code_point(u, 1'b1);
			end else if (r < 95) begin
				// NUL inside the hex digits: the partial code point goes out first.
				send_byte(CH_BSL);
				send_byte(CH_U);
				repeat ($urandom_range(3, 0))
					send_byte(8'(CH_ZERO + $urandom_range(9, 0)));
				send_byte(CH_NUL);
				done = 1'b1;
			end else begin
				send_byte(CH_BSL);
				send_byte(CH_NUL);
				done = 1'b1;
			end
		end
		if (!done)
			send_byte(($urandom_range(4, 0) == 0) ? CH_NUL : CH_QUOTE);
	endtask

	initial begin : stimulus
		logic [7:0] opening [24];
		logic [9:0] plan [8];
		logic [7:0] b;
		int         target;

		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_max_len = 10'd0;
		in_valid = 1'b0;
		in_byte = 8'h00;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed string at the reset limit: a byte with no opening quote,
		// a top byte value, a simple escape, then code points of one, two
		// and three UTF-8 bytes (the last with mixed case and a junk digit).
		opening = '{8'h41, CH_QUOTE, 8'hFF, CH_BSL, CH_N,
			CH_BSL, CH_U, CH_ZERO, CH_ZERO, 8'h34, 8'h31,
			CH_BSL, CH_U, CH_ZERO, 8'h37, 8'h46, 8'h46,
			CH_BSL, CH_U, 8'h46, 8'h66, 8'h7A, 8'h46, CH_QUOTE};
		foreach (opening[i])
			send_byte(opening[i]);

		// Limits to sweep, extremes included; one is drawn at random.
		plan = '{10'd1023, 10'd0, 10'd5, 10'd1, 10'd2, 10'd0, 10'd17, MAX_LEN_RESET};
		plan[5] = 10'($urandom_range(30, 3));

		for (int p = 0; p < 8; p++) begin
			// Walk through every combination of sender and receiver idling.
			tx_gaps = p[0];
			rx_gaps = p[1];

			// Lower the limit while the block sits right after a backslash:
			// the escape byte then has no room and is dropped.
			if (plan[p] == 10'd1) begin
				send_byte(CH_NUL);
				send_byte(CH_QUOTE);
				send_byte(CH_LA);
				send_byte(CH_BSL);
			end
			write_limit(plan[p]);
			if (plan[p] == 10'd1) begin
				send_byte(CH_N);
				send_byte(CH_X);
			end

			// Hold off the receiver for a long stretch while three-byte code
			// points keep coming, so the block backs up and stalls its input.
			if (p == 0) begin
				rx_hold = 150;
				send_byte(CH_QUOTE);
				repeat (8)
					send_code_point(16'($urandom_range(16'hFFFF, 16'h0800)), 1'b0);
				send_byte(CH_QUOTE);
				wait_results_done();
			end

			target = sent + 24;
			while (sent < target) begin
				// Noise between strings: bytes while idle, never a quote.
				if ($urandom_range(6, 0) == 0) begin
					repeat ($urandom_range(2, 1)) begin
						b = 8'($urandom_range(255, 0));
						if (b == CH_QUOTE)
							b = CH_X;
						send_byte(b);
					end
				end
				send_string();
				if ($urandom_range(15, 0) == 0)
					wait_results_done();
			end
		end

		wait_results_done();
		repeat (5) @(negedge clk);

		$display("Covered %0d input bytes and %0d results over %0d length limits,",
			sent, checked, settings);
		$display("from 0 to 1023, with a limit change inside an escape and a long output stall.");
		if (fails == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Give up long after the slowest correct run would have ended.
	initial begin : watchdog
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+src
src/jsu_pkg.sv
src/json_string_unescaper.sv
tb/sv/jsu_checker.sv
tb/sv/tb_json_string_unescaper.sv
